@@ rtl/ocb_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ocb_pkg: shared types and constants for the obstacle cost map binner
// Field widths, request kinds, cell levels, register indexes and defaults.
// ----------------------------------------------------------------------------
package ocb_pkg;

    localparam int COORD_W      = 16;
    localparam int GRID_DIM_W   = 9;
    localparam int CELL_SIZE_W  = 10;
    localparam int COST_W       = 8;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;

    localparam int DEF_MAX_WIDTH    = 256;
    localparam int DEF_MAX_HEIGHT   = 256;
    localparam int DEF_FREE_COST    = 0;
    localparam int DEF_WARN_COST    = 128;
    localparam int DEF_LETHAL_COST  = 254;
    localparam int DEF_UNKNOWN_COST = 255;

    typedef logic [1:0] kind_t;
    localparam kind_t KIND_CLEAR = 2'd0;
    localparam kind_t KIND_POINT = 2'd1;
    localparam kind_t KIND_QUERY = 2'd2;

    typedef logic [1:0] level_t;
    localparam level_t LVL_FREE   = 2'd0;
    localparam level_t LVL_WARN   = 2'd1;
    localparam level_t LVL_LETHAL = 2'd2;

    typedef logic [CFG_IDX_W-1:0] reg_idx_t;
    localparam reg_idx_t REG_GRID_WIDTH  = 3'd0;
    localparam reg_idx_t REG_GRID_HEIGHT = 3'd1;
    localparam reg_idx_t REG_CELL_SIZE   = 3'd2;
    localparam reg_idx_t REG_ORIGIN_X    = 3'd3;
    localparam reg_idx_t REG_ORIGIN_Y    = 3'd4;
    localparam reg_idx_t REG_LETHAL_H    = 3'd5;
    localparam reg_idx_t REG_WARN_H      = 3'd6;

    // magnitude of a 17-bit offset; the range of two 16-bit operands fits 16 bits
    function automatic logic [COORD_W-1:0] offset_mag(input logic signed [COORD_W:0] v);
        logic signed [COORD_W:0] neg;
        neg = -v;
        return v[COORD_W] ? neg[COORD_W-1:0] : v[COORD_W-1:0];
    endfunction

    function automatic logic in_grid(input logic [COORD_W-1:0] q,
                                     input logic [GRID_DIM_W-1:0] dim,
                                     input logic [COORD_W-1:0] max_dim);
        return (q < COORD_W'(dim)) && (q < max_dim);
    endfunction

endpackage
`default_nettype wire

@@ rtl/ocb_divider.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ocb_divider: restoring unsigned divider, one quotient bit per cycle
// 16-bit dividend by 10-bit divisor; done pulses for one cycle at the end.
// ----------------------------------------------------------------------------
module ocb_divider (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    input  wire logic [ocb_pkg::COORD_W-1:0]        dividend,
    input  wire logic [ocb_pkg::CELL_SIZE_W-1:0]    divisor,
    output logic                                    done,
    output logic [ocb_pkg::COORD_W-1:0]             quotient
);
    import ocb_pkg::*;

    localparam int CNT_W = $clog2(COORD_W + 1);

    logic                   busy_reg;
    logic                   done_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [COORD_W-1:0]     quo_reg;
    logic [CELL_SIZE_W-1:0] rem_reg;
    logic [CELL_SIZE_W-1:0] div_reg;

    logic [CELL_SIZE_W:0]   rem_shift;
    logic [CELL_SIZE_W:0]   rem_sub;
    logic                   fits;

    assign rem_shift = {rem_reg, quo_reg[COORD_W-1]};
    assign rem_sub   = rem_shift - {1'b0, div_reg};
    assign fits      = rem_shift >= {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(COORD_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[COORD_W-2:0], fits};
            rem_reg <= fits ? rem_sub[CELL_SIZE_W-1:0] : rem_shift[CELL_SIZE_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

@@ rtl/obstacle_costmap_binner.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// obstacle_costmap_binner: bins obstacle points into a 2-D cost grid
// Point, clear and query requests over one cell-level memory.
// ----------------------------------------------------------------------------
// A point request finds the column and then the row with one shared
// restoring divider that yields one quotient bit per cycle; the cell is
// then read in S_CHECK and written in S_RMW (the point is dropped in
// S_CHECK, and at once when the cell size is zero). A query reads the cell
// in S_QCHK and then waits in S_QRESP for the output register. A clear
// request, reset and every write of registers 0 to 4 run a clearing pass
// over all MAX_WIDTH*MAX_HEIGHT entries of the cell memory (65536 at the
// defaults), one entry per cycle, during which no request is taken;
// configuration writes are taken always.
// in_ready is high only while the block is idle; a query result waits in an
// output register, so the next request can be taken before it is drained.
// ----------------------------------------------------------------------------
module obstacle_costmap_binner #(
    parameter int MAX_WIDTH    = ocb_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT   = ocb_pkg::DEF_MAX_HEIGHT,
    parameter int FREE_COST    = ocb_pkg::DEF_FREE_COST,
    parameter int WARN_COST    = ocb_pkg::DEF_WARN_COST,
    parameter int LETHAL_COST  = ocb_pkg::DEF_LETHAL_COST,
    parameter int UNKNOWN_COST = ocb_pkg::DEF_UNKNOWN_COST
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,

    input  wire logic                                 cfg_we,
    input  wire logic [ocb_pkg::CFG_IDX_W-1:0]        cfg_addr,
    input  wire logic [ocb_pkg::CFG_DATA_W-1:0]       cfg_wdata,

    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic [1:0]                           kind,
    input  wire logic signed [ocb_pkg::COORD_W-1:0]   point_x,
    input  wire logic signed [ocb_pkg::COORD_W-1:0]   point_y,
    input  wire logic signed [ocb_pkg::COORD_W-1:0]   point_z,
    input  wire logic signed [ocb_pkg::COORD_W-1:0]   query_col,
    input  wire logic signed [ocb_pkg::COORD_W-1:0]   query_row,

    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic [ocb_pkg::COST_W-1:0]                cell_cost
);
    import ocb_pkg::*;

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [ADDR_W-1:0]  LAST_ADDR = ADDR_W'(DEPTH - 1);
    localparam logic [ADDR_W-1:0]  ROW_PITCH = ADDR_W'(MAX_WIDTH);
    localparam logic [COORD_W-1:0] MAX_W_Q   = COORD_W'(MAX_WIDTH);
    localparam logic [COORD_W-1:0] MAX_H_Q   = COORD_W'(MAX_HEIGHT);

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_DIVX  = 8'b0000_0100,
        S_DIVY  = 8'b0000_1000,
        S_CHECK = 8'b0001_0000,
        S_RMW   = 8'b0010_0000,
        S_QCHK  = 8'b0100_0000,
        S_QRESP = 8'b1000_0000
    } state_t;

    state_t                 state_reg, state_next;
    logic [ADDR_W-1:0]      clr_cnt_reg, clr_cnt_next;
    logic                   out_valid_reg, out_valid_next;
    logic [COST_W-1:0]      cell_cost_reg;

    logic [GRID_DIM_W-1:0]     grid_width_reg;
    logic [GRID_DIM_W-1:0]     grid_height_reg;
    logic [CELL_SIZE_W-1:0]    cell_size_reg;
    logic signed [COORD_W-1:0] origin_x_reg;
    logic signed [COORD_W-1:0] origin_y_reg;
    logic signed [COORD_W-1:0] lethal_h_reg;
    logic signed [COORD_W-1:0] warn_h_reg;

    logic                      dx_neg_reg;
    logic signed [COORD_W:0]   dy_reg;
    logic signed [COORD_W-1:0] z_reg;
    logic [COORD_W-1:0]        qc_reg;
    logic [COORD_W-1:0]        qr_reg;
    logic [COORD_W-1:0]        qx_reg;
    logic [ADDR_W-1:0]         addr_reg;
    level_t                    level_reg;
    logic                      q_ok_reg;

    level_t                    mem [DEPTH];
    level_t                    rd_data_reg;
    logic [ADDR_W-1:0]         rd_addr;
    logic                      mem_we;
    logic [ADDR_W-1:0]         wr_addr;
    level_t                    wr_data;

    logic                      accept;
    logic                      geo_write;
    logic signed [COORD_W:0]   dx_full;
    logic signed [COORD_W:0]   dy_full;
    logic                      div_start;
    logic [COORD_W-1:0]        div_dividend;
    logic                      div_done;
    logic [COORD_W-1:0]        div_quo;

    logic                      x_ok;
    logic                      y_ok;
    level_t                    level_new;
    logic [ADDR_W-1:0]         pt_addr;
    logic                      q_ok;
    logic [ADDR_W-1:0]         q_addr;
    logic                      out_free;
    logic [COST_W-1:0]         cost_sel;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    assign geo_write = cfg_we && ((cfg_addr == REG_GRID_WIDTH) || (cfg_addr == REG_GRID_HEIGHT)
                                || (cfg_addr == REG_CELL_SIZE) || (cfg_addr == REG_ORIGIN_X)
                                || (cfg_addr == REG_ORIGIN_Y));

    assign dx_full = (COORD_W+1)'(point_x) - (COORD_W+1)'(origin_x_reg);
    assign dy_full = (COORD_W+1)'(point_y) - (COORD_W+1)'(origin_y_reg);

    // truncation toward zero: a negative offset lands in column 0 only if the quotient is 0
    assign x_ok = (!dx_neg_reg || (qx_reg == '0)) && in_grid(qx_reg, grid_width_reg, MAX_W_Q);
    assign y_ok = (!dy_reg[COORD_W] || (div_quo == '0))
                  && in_grid(div_quo, grid_height_reg, MAX_H_Q);

    always_comb
    begin
        if (z_reg >= lethal_h_reg)
            level_new = LVL_LETHAL;
        else if (z_reg >= warn_h_reg)
            level_new = LVL_WARN;
        else
            level_new = LVL_FREE;
    end

    assign pt_addr = ADDR_W'(div_quo) * ROW_PITCH + ADDR_W'(qx_reg);
    assign q_ok    = !qc_reg[COORD_W-1] && !qr_reg[COORD_W-1]
                     && in_grid(qc_reg, grid_width_reg, MAX_W_Q)
                     && in_grid(qr_reg, grid_height_reg, MAX_H_Q);
    assign q_addr  = ADDR_W'(qr_reg) * ROW_PITCH + ADDR_W'(qc_reg);

    always_comb
    begin
        case (rd_data_reg)
            LVL_FREE: cost_sel = COST_W'(FREE_COST);
            LVL_WARN: cost_sel = COST_W'(WARN_COST);
            default:  cost_sel = COST_W'(LETHAL_COST);
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        div_start      = 1'b0;
        div_dividend   = offset_mag(dy_reg);
        rd_addr        = addr_reg;
        mem_we         = 1'b0;
        wr_addr        = addr_reg;
        wr_data        = level_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we       = 1'b1;
                wr_addr      = clr_cnt_reg;
                wr_data      = LVL_FREE;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == LAST_ADDR)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    case (kind)
                        KIND_CLEAR:
                        begin
                            clr_cnt_next = '0;
                            state_next   = S_CLEAR;
                        end
                        KIND_POINT:
                        begin
                            if (cell_size_reg != '0)
                            begin
                                div_start    = 1'b1;
                                div_dividend = offset_mag(dx_full);
                                state_next   = S_DIVX;
                            end
                        end
                        KIND_QUERY:
                            state_next = S_QCHK;
                        default:
                            state_next = S_IDLE;
                    endcase
                end
            end
            S_DIVX:
            begin
                if (div_done)
                begin
                    div_start  = 1'b1;
                    state_next = S_DIVY;
                end
            end
            S_DIVY:
            begin
                if (div_done)
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                rd_addr = pt_addr;
                if (x_ok && y_ok && (level_new != LVL_FREE))
                    state_next = S_RMW;
                else
                    state_next = S_IDLE;
            end
            S_RMW:
            begin
                mem_we     = level_reg > rd_data_reg;
                state_next = S_IDLE;
            end
            S_QCHK:
            begin
                rd_addr    = q_addr;
                state_next = S_QRESP;
            end
            S_QRESP:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase

        if (geo_write)
        begin
            clr_cnt_next = '0;
            state_next   = S_CLEAR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            clr_cnt_reg     <= '0;
            out_valid_reg   <= 1'b0;
            grid_width_reg  <= GRID_DIM_W'(256);
            grid_height_reg <= GRID_DIM_W'(256);
            cell_size_reg   <= CELL_SIZE_W'(100);
            origin_x_reg    <= '0;
            origin_y_reg    <= '0;
            lethal_h_reg    <= COORD_W'(300);
            warn_h_reg      <= COORD_W'(100);
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_GRID_WIDTH:  grid_width_reg  <= cfg_wdata[GRID_DIM_W-1:0];
                    REG_GRID_HEIGHT: grid_height_reg <= cfg_wdata[GRID_DIM_W-1:0];
                    REG_CELL_SIZE:   cell_size_reg   <= cfg_wdata[CELL_SIZE_W-1:0];
                    REG_ORIGIN_X:    origin_x_reg    <= cfg_wdata;
                    REG_ORIGIN_Y:    origin_y_reg    <= cfg_wdata;
                    REG_LETHAL_H:    lethal_h_reg    <= cfg_wdata;
                    REG_WARN_H:      warn_h_reg      <= cfg_wdata;
                    default:         ;
                endcase
            end
        end
    end

    // request payload and intermediate results
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            dx_neg_reg <= dx_full[COORD_W];
            dy_reg     <= dy_full;
            z_reg      <= point_z;
            qc_reg     <= query_col;
            qr_reg     <= query_row;
        end
        if ((state_reg == S_DIVX) && div_done)
            qx_reg <= div_quo;
        if (state_reg == S_CHECK)
        begin
            addr_reg  <= pt_addr;
            level_reg <= level_new;
        end
        if (state_reg == S_QCHK)
        begin
            addr_reg <= q_addr;
            q_ok_reg <= q_ok;
        end
        if ((state_reg == S_QRESP) && out_free)
            cell_cost_reg <= q_ok_reg ? cost_sel : COST_W'(UNKNOWN_COST);
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    ocb_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (cell_size_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign out_valid = out_valid_reg;
    assign cell_cost = cell_cost_reg;

    // a cell is only ever raised, never lowered, by a point
    a_rmw_raises: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RMW && mem_we) |-> (level_reg > rd_data_reg))
        else $error("cell write does not raise the level");

    a_result_from_query: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_QRESP))
        else $error("result appeared without a query");

    a_clear_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(rst_n) && state_reg == S_CLEAR && $past(state_reg == S_CLEAR)
         && !$past(geo_write))
        |-> (clr_cnt_reg == $past(clr_cnt_reg) + 1'b1))
        else $error("clearing pass skipped an entry");

endmodule
`default_nettype wire
